[hw/rtl/poi_pkg.sv]
// ----------------------------------------------------------------------------
// poi_pkg: shared types and constants for the planar odometry integrator
// Request payloads, divider width and the CORDIC angle table.
// ----------------------------------------------------------------------------
package poi_pkg;

	// Input request: tick, body velocities, yaw rate
	typedef struct packed {
		logic        [31:0] tick_ms;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_z;
		logic signed [15:0] yaw_rate;
	} sample_t;

	// Output request: integrated pose
	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic        [15:0] pose_yaw;
		logic signed [31:0] pose_height;
		logic               clipped;
	} pose_t;

	// Dividend / quotient width of the rounding divider
	localparam int DIV_W = 49;

	// CORDIC start value, Q30, pre-scaled by the inverse gain
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] val;
		case (idx)
			5'd0:    val = 32'd536870912;
			5'd1:    val = 32'd316933406;
			5'd2:    val = 32'd167458907;
			5'd3:    val = 32'd85004756;
			5'd4:    val = 32'd42667331;
			5'd5:    val = 32'd21354465;
			5'd6:    val = 32'd10679838;
			5'd7:    val = 32'd5340245;
			5'd8:    val = 32'd2670163;
			5'd9:    val = 32'd1335087;
			5'd10:   val = 32'd667544;
			5'd11:   val = 32'd333772;
			5'd12:   val = 32'd166886;
			5'd13:   val = 32'd83443;
			5'd14:   val = 32'd41722;
			5'd15:   val = 32'd20861;
			5'd16:   val = 32'd10430;
			5'd17:   val = 32'd5215;
			5'd18:   val = 32'd2608;
			5'd19:   val = 32'd1304;
			5'd20:   val = 32'd652;
			5'd21:   val = 32'd326;
			5'd22:   val = 32'd163;
			5'd23:   val = 32'd81;
			default: val = 32'd0;
		endcase
		return val;
	endfunction

endpackage

[hw/rtl/poi_cordic.sv]
// ----------------------------------------------------------------------------
// poi_cordic: iterative sine / cosine unit
// One CORDIC rotation per cycle in Q30 over the low 30 angle bits; the top
// two bits select the quadrant on the way out. Results hold until next start.
// ----------------------------------------------------------------------------
module poi_cordic
	import poi_pkg::*;
#(
	parameter int unsigned STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               busy,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	localparam int IDX_W = $clog2(STEPS);

	logic signed [31:0] x_q, y_q, z_q;
	logic        [1:0]  quad_q;
	logic [IDX_W-1:0]   idx_q;
	logic               run_q;

	logic signed [31:0] xs, ys, at;

	// Shifted terms and table angle for this rotation
	always_comb begin
		xs = x_q >>> idx_q;
		ys = y_q >>> idx_q;
		at = signed'(atan_turn(5'(idx_q)));
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			idx_q <= '0;
		end else if (run_q) begin
			if (idx_q == IDX_W'(STEPS - 1)) begin
				run_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Rotation datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= signed'({2'b00, angle[29:0]});
			quad_q <= angle[31:30];
		end else if (run_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy = run_q;

	// Quadrant fold
	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = x_q;
				sin_val = y_q;
			end
			2'd1: begin
				cos_val = -y_q;
				sin_val = x_q;
			end
			2'd2: begin
				cos_val = -x_q;
				sin_val = -y_q;
			end
			default: begin
				cos_val = y_q;
				sin_val = -x_q;
			end
		endcase
	end

endmodule

[hw/rtl/poi_div.sv]
// ----------------------------------------------------------------------------
// poi_div: reciprocal-multiply divider by a fixed divisor
// The quotient is the top of dividend * reciprocal, built from four 31-bit
// limb products on the shared multiplier, one per cycle. Exact for every
// dividend below 2^DIV_W; the quotient holds once the unit goes idle.
// ----------------------------------------------------------------------------
module poi_div
	import poi_pkg::*;
#(
	parameter int unsigned DIVISOR = 1000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   dividend,
	output logic               busy,
	output logic [DIV_W-1:0]   quotient,
	output logic signed [31:0] mul_a,
	output logic signed [31:0] mul_b,
	input  logic signed [63:0] mul_p
);

	localparam int LIMB  = 31;
	localparam int ACC_W = 70;
	localparam int LOG_D = $clog2(DIVISOR);
	localparam int SHIFT = DIV_W + LOG_D;

	// floor(2^SHIFT / DIVISOR) + 1, always below 2^(DIV_W+1)
	localparam logic [127:0]    RECIP    = ((128'd1 << SHIFT) / 128'(DIVISOR)) + 128'd1;
	localparam logic [LIMB-1:0] RECIP_LO = RECIP[LIMB-1:0];
	localparam logic [LIMB-1:0] RECIP_HI = RECIP[2*LIMB-1:LIMB];

	// Limb products, low first
	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;
	localparam logic [1:0] STEP_HH = 2'd3;

	logic             run_q;
	logic [1:0]       step_q;
	logic [DIV_W-1:0] dvd_q;
	logic [ACC_W-1:0] acc_q;

	logic [LIMB-1:0]  n_lo, n_hi, opa, opb;
	logic [63:0]      prod_u;

	// Limb operands for this step
	always_comb begin
		n_lo = dvd_q[LIMB-1:0];
		n_hi = LIMB'(dvd_q >> LIMB);
		case (step_q)
			STEP_LL: begin
				opa = n_lo;
				opb = RECIP_LO;
			end
			STEP_LH: begin
				opa = n_lo;
				opb = RECIP_HI;
			end
			STEP_HL: begin
				opa = n_hi;
				opb = RECIP_LO;
			end
			default: begin
				opa = n_hi;
				opb = RECIP_HI;
			end
		endcase
		prod_u = mul_p;
	end

	assign mul_a = signed'({1'b0, opa});
	assign mul_b = signed'({1'b0, opb});

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= STEP_LL;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= STEP_LL;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_HH) begin
				run_q <= 1'b0;
			end
		end
	end

	// Accumulate the product scaled down by one limb; low bits of the
	// lowest product only feed the floor
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end else if (run_q) begin
			case (step_q)
				STEP_LL: acc_q <= ACC_W'(prod_u[63:LIMB]);
				STEP_HH: acc_q <= acc_q + (ACC_W'(prod_u) << LIMB);
				default: acc_q <= acc_q + ACC_W'(prod_u);
			endcase
		end
	end

	assign busy     = run_q;
	assign quotient = DIV_W'(acc_q >> (SHIFT - LIMB));

endmodule

[hw/rtl/planar_odometry_integrator.sv]
// ----------------------------------------------------------------------------
// planar_odometry_integrator: dead-reckoning pose integrator
// Elapsed time from the tick, body velocity turned into the world frame by
// the held heading, and x, y, height and heading integrated with rounding.
//
//   channel   handshake                     payload           dir
//   sample    sample_valid / sample_stall   sample (sample_t)  in
//   pose      pose_valid / pose_stall       pose (pose_t)      out
//   config    default_step_we               default_step_ms    in
//
// A sample is taken only in idle, so a new one waits until the last pose has
// reached the output register. Each sample passes the four scalar products
// and the CORDIC wait, then x and y, then height and heading, each through the
// absolute value, rounding offset and divide (the divide borrows the shared
// multiplier), then the output register. Reset puts the pose at the origin,
// clears the held tick and sets the default step to 1 ms. A finished pose
// waits in an output register, so a new sample is taken while pose_stall is
// high; the block only stops if a second pose is ready before the first has
// gone.
// ----------------------------------------------------------------------------
module planar_odometry_integrator
	import poi_pkg::*;
#(
	parameter int unsigned TICKS_PER_SECOND = 1000,
	parameter int unsigned TRIG_STEPS       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        pose_valid,
	input  logic        pose_stall,
	output pose_t       pose,
	input  logic        default_step_we,
	input  logic [9:0]  default_step_ms
);

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PRE   = 4'd1;
	localparam logic [3:0] S_TRIG  = 4'd2;
	localparam logic [3:0] S_M1    = 4'd3;
	localparam logic [3:0] S_M2    = 4'd4;
	localparam logic [3:0] S_M3    = 4'd5;
	localparam logic [3:0] S_LOAD  = 4'd6;
	localparam logic [3:0] S_ABS   = 4'd7;
	localparam logic [3:0] S_BIAS  = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_APPLY = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	// Integration targets, in processing order
	localparam logic [1:0] OP_X = 2'd0;
	localparam logic [1:0] OP_Y = 2'd1;
	localparam logic [1:0] OP_H = 2'd2;
	localparam logic [1:0] OP_W = 2'd3;

	// Rounding offsets: half the full divisor
	localparam logic [65:0] BIAS_POS = 66'(TICKS_PER_SECOND) << 25;
	localparam logic [65:0] BIAS_SCL = 66'(TICKS_PER_SECOND / 2);

	logic [3:0]         state_q;
	logic [1:0]         pstep_q;
	logic [1:0]         op_q;
	logic [9:0]         step_cfg_q;
	logic [31:0]        prev_tick_q;
	logic signed [31:0] pos_x_q, pos_y_q, height_q;
	logic [31:0]        yaw_q;
	logic               clip_q;
	logic               pose_valid_q;

	sample_t            smp_q;
	logic [15:0]        dt_q;
	logic signed [31:0] pa_q, pb_q, ph_q, pw_q;
	logic signed [63:0] prod_s1;
	logic signed [64:0] num_q;
	logic [64:0]        mag_q;
	logic               neg_q;
	pose_t              pose_q;

	logic               take_in;
	logic [31:0]        elapsed;
	logic               gap_sat;
	logic [15:0]        dt_new;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;

	logic signed [31:0] cos_v, sin_v;
	logic               trig_busy;

	logic [65:0]        biased;
	logic [DIV_W-1:0]   dvd;
	logic               div_busy;
	logic [DIV_W-1:0]   quot;
	logic signed [31:0] div_mul_a, div_mul_b;

	logic signed [49:0] delta;
	logic signed [31:0] acc_sel;
	logic signed [50:0] acc_sum;
	logic signed [31:0] acc_new;
	logic               acc_clip;
	logic               out_load;

	assign take_in      = sample_valid && !sample_stall;
	assign sample_stall = (state_q != S_IDLE);

	// Elapsed time, saturated at 16 bits; the default step while the held tick is zero
	always_comb begin
		elapsed = sample.tick_ms - prev_tick_q;
		gap_sat = (prev_tick_q != '0) && (elapsed[31:16] != '0);
		if (prev_tick_q == '0) begin
			dt_new = {6'd0, step_cfg_q};
		end else if (gap_sat) begin
			dt_new = 16'hFFFF;
		end else begin
			dt_new = elapsed[15:0];
		end
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = pa_q;
		mul_b = signed'({16'd0, dt_q});
		case (state_q)
			S_PRE: begin
				case (pstep_q)
					2'd0:    mul_a = 32'(smp_q.vel_x);
					2'd1:    mul_a = 32'(smp_q.vel_y);
					2'd2:    mul_a = 32'(smp_q.vel_z);
					default: mul_a = 32'(smp_q.yaw_rate);
				endcase
			end
			S_M1: begin
				mul_a = pa_q;
				mul_b = (op_q == OP_X) ? cos_v : sin_v;
			end
			S_M2: begin
				mul_a = pb_q;
				mul_b = (op_q == OP_X) ? sin_v : cos_v;
			end
			S_DIV: begin
				mul_a = div_mul_a;
				mul_b = div_mul_b;
			end
			default: begin
				mul_a = pa_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	poi_cordic #(
		.STEPS (TRIG_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (take_in),
		.angle   (yaw_q),
		.busy    (trig_busy),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// Rounding offset and pre-shift ahead of the divider
	always_comb begin
		if (op_q inside {OP_X, OP_Y}) begin
			biased = {1'b0, mag_q} + BIAS_POS;
			dvd    = DIV_W'(biased >> 26);
		end else begin
			biased = {1'b0, mag_q} + BIAS_SCL;
			dvd    = biased[DIV_W-1:0];
		end
	end

	poi_div #(
		.DIVISOR (TICKS_PER_SECOND)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_BIAS),
		.dividend (dvd),
		.busy     (div_busy),
		.quotient (quot),
		.mul_a    (div_mul_a),
		.mul_b    (div_mul_b),
		.mul_p    (mul_p)
	);

	// Signed step and saturating accumulate
	always_comb begin
		delta = neg_q ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
		case (op_q)
			OP_X:    acc_sel = pos_x_q;
			OP_Y:    acc_sel = pos_y_q;
			default: acc_sel = height_q;
		endcase
		acc_sum  = 51'(acc_sel) + 51'(delta);
		acc_clip = 1'b1;
		if (acc_sum > 51'sd2147483647) begin
			acc_new = 32'sh7FFFFFFF;
		end else if (acc_sum < -51'sd2147483648) begin
			acc_new = 32'sh80000000;
		end else begin
			acc_new  = acc_sum[31:0];
			acc_clip = 1'b0;
		end
	end

	assign out_load = (state_q == S_OUT) && (!pose_valid_q || !pose_stall);

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pstep_q      <= '0;
			op_q         <= OP_X;
			step_cfg_q   <= 10'd1;
			prev_tick_q  <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			height_q     <= '0;
			yaw_q        <= '0;
			clip_q       <= 1'b0;
			pose_valid_q <= 1'b0;
		end else begin
			if (default_step_we) begin
				step_cfg_q <= default_step_ms;
			end
			if (out_load) begin
				pose_valid_q <= 1'b1;
			end else if (!pose_stall) begin
				pose_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take_in) begin
						prev_tick_q <= sample.tick_ms;
						clip_q      <= gap_sat;
						pstep_q     <= '0;
						state_q     <= S_PRE;
					end
				end
				S_PRE: begin
					pstep_q <= pstep_q + 1'b1;
					if (pstep_q == 2'd3) begin
						state_q <= S_TRIG;
					end
				end
				S_TRIG: begin
					if (!trig_busy) begin
						op_q    <= OP_X;
						state_q <= S_M1;
					end
				end
				S_M1:   state_q <= S_M2;
				S_M2:   state_q <= S_M3;
				S_M3:   state_q <= S_ABS;
				S_LOAD: state_q <= S_ABS;
				S_ABS:  state_q <= S_BIAS;
				S_BIAS: state_q <= S_DIV;
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					case (op_q)
						OP_X:    pos_x_q  <= acc_new;
						OP_Y:    pos_y_q  <= acc_new;
						OP_H:    height_q <= acc_new;
						default: yaw_q    <= yaw_q + delta[31:0];
					endcase
					if (op_q != OP_W) begin
						clip_q <= clip_q | acc_clip;
					end
					if (op_q == OP_W) begin
						state_q <= S_OUT;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= (op_q == OP_X) ? S_M1 : S_LOAD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			smp_q <= sample;
			dt_q  <= dt_new;
		end
		// scalar products v*dt, each fits 32 bits
		if (state_q == S_PRE) begin
			case (pstep_q)
				2'd0:    pa_q <= mul_p[31:0];
				2'd1:    pb_q <= mul_p[31:0];
				2'd2:    ph_q <= mul_p[31:0];
				default: pw_q <= mul_p[31:0];
			endcase
		end
		if (state_q == S_M1 || state_q == S_M2) begin
			prod_s1 <= mul_p;
		end
		// numerator build
		case (state_q)
			S_M2: num_q <= {prod_s1[63], prod_s1};
			S_M3: begin
				if (op_q == OP_X) begin
					num_q <= num_q - {prod_s1[63], prod_s1};
				end else begin
					num_q <= num_q + {prod_s1[63], prod_s1};
				end
			end
			S_LOAD: begin
				if (op_q == OP_H) begin
					num_q <= {{29{ph_q[31]}}, ph_q, 4'd0};
				end else begin
					num_q <= {{17{pw_q[31]}}, pw_q, 16'd0};
				end
			end
			default: num_q <= num_q;
		endcase
		if (state_q == S_ABS) begin
			neg_q <= num_q[64];
			mag_q <= num_q[64] ? (~num_q + 65'd1) : num_q;
		end
		if (out_load) begin
			pose_q.pose_x      <= pos_x_q;
			pose_q.pose_y      <= pos_y_q;
			pose_q.pose_yaw    <= yaw_q[31:16];
			pose_q.pose_height <= height_q;
			pose_q.clipped     <= clip_q;
		end
	end

	assign pose_valid = pose_valid_q;
	assign pose       = pose_q;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the planar odometry integrator
// A directed table of samples (reset pose, speed and tick extremes, tick wrap,
// zero ticks, zero and full default step) is followed by random runs of
// smooth, noisy, gap-edge and saturating climb samples. Each accepted request
// is run through an in-bench pose integrator and every returned pose is
// compared field by field, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
	import poi_pkg::*;

	localparam int unsigned      TRIG_STEPS  = 16;
	localparam longint unsigned  TPS         = 1000;
	localparam longint           TRIG_START  = 64'sd652032874;
	localparam longint           POS_MAX     = 64'sd2147483647;
	localparam longint           POS_MIN     = -64'sd2147483648;
	localparam int               CYCLE_LIMIT = 2000000;
	localparam int               SETTLE      = 300;
	localparam int               HOLD_CYCLES = 3000;
	localparam bit [15:0]        VMAX        = 16'h7FFF;
	localparam bit [15:0]        VMIN        = 16'h8000;

	// atan(2^-i) in 2^-32 turn
	localparam longint ATAN_TURN [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// Directed row: optional step write, sample, optional hand-worked pose
	typedef struct packed {
		bit        cfg_wr;
		bit [9:0]  cfg_val;
		bit [31:0] tick;
		bit [15:0] vx;
		bit [15:0] vy;
		bit [15:0] vz;
		bit [15:0] rate;
		bit        typed;
		bit [31:0] px;
		bit [31:0] py;
		bit [15:0] yaw;
		bit [31:0] height;
		bit        clip;
	} stim_row_t;

	localparam int N_DIRECTED = 22;
	localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
		// origin after reset, 1 ms default step
		'{1'b0, 10'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			1'b1, 32'd0, 32'd0, 16'd0, 32'd0, 1'b0},
		'{1'b0, 10'd0, 32'd0, 16'd0, 16'd0, VMAX, 16'd0,
			1'b1, 32'd0, 32'd0, 16'd0, 32'sd524, 1'b0},
		// one second default step, full downward speed
		'{1'b1, 10'd1000, 32'd0, 16'd0, 16'd0, VMIN, 16'd0,
			1'b1, 32'd0, 32'd0, 16'd0, -32'sd523764, 1'b0},
		// quarter turn of heading
		'{1'b0, 10'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384,
			1'b1, 32'd0, 32'd0, 16'd16384, -32'sd523764, 1'b0},
		'{1'b0, 10'd0, 32'd1000, VMAX, 16'd0, 16'd0, 16'd0, 1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'd1010, VMIN, VMAX, 16'd0, VMIN, 1'b0, '0, '0, '0, '0, 1'b0},
		// repeated tick: no time passes
		'{1'b0, 10'd0, 32'd1010, VMAX, VMAX, VMAX, VMAX, 1'b0, '0, '0, '0, '0, 1'b0},
		// tick going backwards wraps to a long gap
		'{1'b0, 10'd0, 32'd1009, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'd71009, VMAX, VMIN, VMIN, VMAX, 1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'hFFFF_FFF0, 16'h1234, 16'hEDCB, VMAX, 16'h0100,
			1'b0, '0, '0, '0, '0, 1'b0},
		// short step across the 2^32 wrap
		'{1'b0, 10'd0, 32'd5, 16'h5A5A, 16'hA5A5, 16'h0001, 16'hFFFF,
			1'b0, '0, '0, '0, '0, 1'b0},
		// zero tick is stored, next step falls back to the default
		'{1'b0, 10'd0, 32'd0, 16'h0F0F, 16'hF0F0, 16'hFFFF, VMIN,
			1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'd20, VMAX, VMAX, VMIN, VMAX, 1'b0, '0, '0, '0, '0, 1'b0},
		// zero default step; once a zero tick is held, the pose is left alone
		'{1'b1, 10'd0, 32'd0, VMIN, VMIN, VMAX, VMIN, 1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'd0, VMAX, VMAX, VMAX, VMAX, 1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'd7, VMIN, VMIN, VMIN, VMIN, 1'b0, '0, '0, '0, '0, 1'b0},
		// all-ones default step
		'{1'b1, 10'd1023, 32'd0, 16'h4000, 16'hC000, 16'h2000, 16'h0800,
			1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'd100, 16'hC000, 16'h4000, 16'hE000, 16'hF800,
			1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF, 16'h8001, 16'h7FFE,
			1'b0, '0, '0, '0, '0, 1'b0},
		// largest gap that does not saturate, then one more
		'{1'b0, 10'd0, 32'd65534, 16'h2AAA, 16'hD555, 16'h5555, 16'hAAAA,
			1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b0, 10'd0, 32'd131070, 16'h3333, 16'hCCCC, 16'h00FF, 16'hFF00,
			1'b0, '0, '0, '0, '0, 1'b0},
		'{1'b1, 10'd1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0, '0, '0, '0, 1'b0}
	};

	logic       clk             = 1'b0;
	logic       arst_n          = 1'b0;
	logic       sample_valid    = 1'b0;
	logic       sample_stall;
	sample_t    sample          = '0;
	logic       pose_valid;
	logic       pose_stall      = 1'b0;
	pose_t      pose;
	logic       default_step_we = 1'b0;
	logic [9:0] default_step_ms = '0;

	// Integrator state mirrored in the bench
	int        est_x         = 0;
	int        est_y         = 0;
	int        est_h         = 0;
	bit [31:0] est_heading   = '0;
	bit [31:0] est_last_tick = '0;
	bit [9:0]  est_step_ms   = 10'd1;

	pose_t     pending_poses [$];
	bit [31:0] tick_now      = '0;
	int        tx_idle_pct   = 0;
	int        rx_idle_pct   = 0;
	bit        hold_phase    = 1'b0;
	bit        hold_done     = 1'b0;
	int        hold_left     = 0;
	int        errors        = 0;
	int        cycle_count   = 0;

	planar_odometry_integrator #(
		.TICKS_PER_SECOND(1000),
		.TRIG_STEPS(TRIG_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.pose_valid(pose_valid),
		.pose_stall(pose_stall),
		.pose(pose),
		.default_step_we(default_step_we),
		.default_step_ms(default_step_ms)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// CORDIC sine and cosine of the heading, Q30
	function automatic void heading_sin_cos(input bit [31:0] ang, output longint cos_v,
			output longint sin_v);
		longint x, y, z, xs, ys;
		x = TRIG_START;
		y = 0;
		z = longint'({2'b00, ang[29:0]});
		for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURN[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURN[i];
			end
		end
		case (ang[31:30])
			2'd0: begin cos_v = x;  sin_v = y;  end
			2'd1: begin cos_v = -y; sin_v = x;  end
			2'd2: begin cos_v = -x; sin_v = -y; end
			default: begin cos_v = y;  sin_v = -x; end
		endcase
	endfunction

	// Divide, rounding to nearest with halves away from zero
	function automatic longint round_nearest(input longint num, input longint unsigned den);
		longint unsigned mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic int sat_accumulate(input int acc, input longint d, inout bit clip);
		longint sum;
		sum = acc + d;
		if (sum > POS_MAX) begin
			clip = 1'b1;
			return int'(POS_MAX);
		end
		if (sum < POS_MIN) begin
			clip = 1'b1;
			return int'(POS_MIN);
		end
		return int'(sum);
	endfunction

	// One integration step; updates the mirrored state, returns the new pose
	function automatic pose_t advance_pose(input sample_t s);
		longint    dt, c, sn, wx, wy, vx, vy, vz, wr;
		bit [31:0] gap;
		bit        clip;
		pose_t     p;
		vx = s.vel_x;
		vy = s.vel_y;
		vz = s.vel_z;
		wr = s.yaw_rate;
		clip = 1'b0;
		if (est_last_tick == 0) begin
			dt = est_step_ms;
		end else begin
			gap = s.tick_ms - est_last_tick;
			if (gap > 32'd65535) begin
				gap = 32'd65535;
				clip = 1'b1;
			end
			dt = gap;
		end
		est_last_tick = s.tick_ms;
		heading_sin_cos(est_heading, c, sn);
		wx = vx * c - vy * sn;
		wy = vx * sn + vy * c;
		est_x = sat_accumulate(est_x, round_nearest(wx * dt, TPS << 26), clip);
		est_y = sat_accumulate(est_y, round_nearest(wy * dt, TPS << 26), clip);
		est_h = sat_accumulate(est_h, round_nearest(vz * dt * 16, TPS), clip);
		est_heading = est_heading + 32'(round_nearest(wr * dt * 65536, TPS));
		p.pose_x = est_x;
		p.pose_y = est_y;
		p.pose_yaw = est_heading[31:16];
		p.pose_height = est_h;
		p.clipped = clip;
		return p;
	endfunction

	function automatic sample_t scrambled(input bit [31:0] t);
		sample_t s;
		s.tick_ms = t;
		s.vel_x = 16'($urandom);
		s.vel_y = 16'($urandom);
		s.vel_z = 16'($urandom);
		s.yaw_rate = 16'($urandom);
		return s;
	endfunction

	task automatic note_error(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			note_error($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Offer one request from a falling edge; returns at the falling edge after it is taken
	task automatic offer(input sample_t smp, input bit typed, input pose_t typed_pose);
		pose_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= smp;
		do @(posedge clk); while (sample_stall);
		predicted = advance_pose(smp);
		pending_poses.push_back(typed ? typed_pose : predicted);
		@(negedge clk);
	endtask

	task automatic wait_for_poses();
		sample_valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(negedge clk);
	endtask

	// Step register is only written once the block has gone quiet
	task automatic write_step(input bit [9:0] val);
		wait_for_poses();
		default_step_ms <= val;
		default_step_we <= 1'b1;
		@(negedge clk);
		default_step_we <= 1'b0;
		est_step_ms = val;
	endtask

	// Random requests in runs: smooth motion, noise, gap edges and saturating climbs
	task automatic run_random(input int count);
		int        sent, kind, len;
		bit        up;
		bit [15:0] mag;
		sample_t   s;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				len = $urandom_range(5, 30);
				repeat (len) begin
					if ($urandom_range(0, 19) == 0)
						tick_now = '0;
					else if ($urandom_range(0, 9) == 0)
						tick_now += $urandom_range(51, 3000);
					else
						tick_now += $urandom_range(1, 50);
					offer(scrambled(tick_now), 1'b0, '0);
				end
			end else if (kind < 75) begin
				len = $urandom_range(1, 5);
				repeat (len) begin
					tick_now = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
					offer(scrambled(tick_now), 1'b0, '0);
				end
			end else if (kind < 95) begin
				len = $urandom_range(1, 4);
				repeat (len) begin
					case ($urandom_range(0, 3))
						0: tick_now += 32'd65534;
						1: tick_now += 32'd65535;
						2: tick_now += 32'd65536;
						default: tick_now += $urandom;
					endcase
					offer(scrambled(tick_now), 1'b0, '0);
				end
			end else begin
				// near-full speed over long steps drives the positions into saturation
				len = $urandom_range(75, 90);
				up = $urandom_range(0, 1);
				mag = 16'(32512 + $urandom_range(0, 255));
				repeat (len) begin
					tick_now += $urandom_range(60000, 65535);
					s.tick_ms = tick_now;
					s.vel_x = up ? mag : -mag;
					s.vel_y = 16'($urandom);
					s.vel_z = up ? mag : -mag;
					s.yaw_rate = '0;
					offer(s, 1'b0, '0);
				end
			end
			sent += len;
		end
	endtask

	// Receiver: random stall, plus one long hold-off once the last phase starts
	always @(negedge clk) begin
		if (hold_phase && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pose_stall <= 1'b1;
		end else begin
			pose_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Pose checker
	always @(posedge clk) begin
		pose_t want;
		if (arst_n && pose_valid && !pose_stall) begin
			if (pending_poses.size() == 0) begin
				note_error($sformatf("pose with none outstanding, x=%0d y=%0d",
					pose.pose_x, pose.pose_y));
			end else begin
				want = pending_poses.pop_front();
				check_field("pose_x", pose.pose_x, want.pose_x);
				check_field("pose_y", pose.pose_y, want.pose_y);
				check_field("pose_yaw", pose.pose_yaw, want.pose_yaw);
				check_field("pose_height", pose.pose_height, want.pose_height);
				check_field("clipped", pose.clipped, want.clipped);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		stim_row_t r;
		sample_t   s;
		pose_t     tp;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, sender mostly offering and receiver mostly stalling
		tx_idle_pct = 24;
		rx_idle_pct = 74;
		for (int i = 0; i < N_DIRECTED; i++) begin
			r = DIRECTED[i];
			if (r.cfg_wr)
				write_step(r.cfg_val);
			s.tick_ms = r.tick;
			s.vel_x = r.vx;
			s.vel_y = r.vy;
			s.vel_z = r.vz;
			s.yaw_rate = r.rate;
			tp.pose_x = r.px;
			tp.pose_y = r.py;
			tp.pose_yaw = r.yaw;
			tp.pose_height = r.height;
			tp.clipped = r.clip;
			offer(s, r.typed, tp);
		end

		write_step(10'd1000);
		run_random(300);

		// receiver eager, sender sparse
		write_step(10'($urandom_range(0, 1023)));
		tx_idle_pct = 74;
		rx_idle_pct = 24;
		run_random(300);

		// back to back, opening with a long receiver hold-off
		write_step(10'd1);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_phase = 1'b1;
		run_random(150);
		write_step(10'($urandom_range(1, 1000)));
		run_random(150);

		wait_for_poses();
		repeat (SETTLE) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
